/* src/assert_macros.svh */
// Assertion macros used by the port-level checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is asserted.
`define PPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

/* src/ppa_pkg.sv */
// Types, codes and sizes shared by the page pool allocator modules.
package ppa_pkg;

  // Pool capacity and derived widths
  localparam int MAX_PAGES = 1024;
  localparam int IDX_W     = $clog2(MAX_PAGES);
  localparam int CNT_W     = $clog2(MAX_PAGES + 1);

  // Field widths
  localparam int KIND_W   = 3;
  localparam int PAGE_W   = 10;
  localparam int STATUS_W = 2;
  localparam int OFFSET_W = 34;

  // Configuration register widths
  localparam int POOL_W = 11;
  localparam int TPP_W  = 9;
  localparam int HC_W   = 8;
  localparam int HW_W   = 10;
  localparam int CFG_W  = 11;
  localparam int CFGI_W = 2;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FREE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LOCATE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RESET  = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_INVALID   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOT_ALLOC = 2'd3;

  // Configuration register indexes
  localparam logic [CFGI_W-1:0] CFG_POOL_PAGES      = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_TOKENS_PER_PAGE = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_HEAD_COUNT      = 2'd2;
  localparam logic [CFGI_W-1:0] CFG_HEAD_WIDTH      = 2'd3;

  // Input transaction
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PAGE_W-1:0] page_id;
  } ppa_in_t;

  // Result transaction
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   page_number;
    logic                allocated_flag;
    logic [OFFSET_W-1:0] element_offset;
  } ppa_out_t;

  // Access bundle for the stack and bitmap memories
  typedef struct packed {
    logic [IDX_W-1:0] map_rd_addr;
    logic [IDX_W-1:0] stk_rd_addr;
    logic             stk_we;
    logic [IDX_W-1:0] stk_waddr;
    logic [IDX_W-1:0] stk_wdata;
    logic             map_we;
    logic [IDX_W-1:0] map_waddr;
    logic             map_wdata;
  } ppa_mem_req_t;

endpackage

/* src/ppa_store.sv */
// Free page stack and allocated bitmap memories, with registered reads.
module ppa_store (
  input  logic                      clk,
  input  ppa_pkg::ppa_mem_req_t     req,
  output logic [ppa_pkg::IDX_W-1:0] stk_rd,
  output logic                      map_rd
);
  import ppa_pkg::*;

  logic [IDX_W-1:0] stk_mem [MAX_PAGES];
  logic             map_mem [MAX_PAGES];

  // Write and read the free stack
  always_ff @(posedge clk) begin
    if (req.stk_we) begin
      stk_mem[req.stk_waddr] <= req.stk_wdata;
    end
    stk_rd <= stk_mem[req.stk_rd_addr];
  end

  // Write and read the allocated bitmap
  always_ff @(posedge clk) begin
    if (req.map_we) begin
      map_mem[req.map_waddr] <= req.map_wdata;
    end
    map_rd <= map_mem[req.map_rd_addr];
  end

endmodule

/* src/ppa_offset.sv */
// Three-stage multiplier chain for page * tokens * heads * head width.
module ppa_offset (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ppa_pkg::PAGE_W-1:0]   page,
  input  logic [ppa_pkg::TPP_W-1:0]    tokens_per_page,
  input  logic [ppa_pkg::HC_W-1:0]     head_count,
  input  logic [ppa_pkg::HW_W-1:0]     head_width,
  output logic                         done,
  output logic [ppa_pkg::OFFSET_W-1:0] offset
);
  import ppa_pkg::*;

  localparam int S1_W = PAGE_W + TPP_W;
  localparam int S2_W = S1_W + HC_W;
  localparam int S3_W = S2_W + HW_W;

  logic [TPP_W-1:0] tpp_sat;
  logic [HC_W-1:0]  hc_sat;
  logic [HW_W-1:0]  hw_sat;
  logic [S1_W-1:0]  s1_r;
  logic [S2_W-1:0]  s2_r;
  logic [S3_W-1:0]  s3_r;
  logic             v1_r, v2_r, v3_r;

  // Saturate the geometry to its upper bounds
  assign tpp_sat = (tokens_per_page > 9'd256) ? 9'd256 : tokens_per_page;
  assign hc_sat  = (head_count > 8'd128) ? 8'd128 : head_count;
  assign hw_sat  = (head_width > 10'd512) ? 10'd512 : head_width;

  // Advance the product one factor per stage
  always_ff @(posedge clk) begin
    s1_r <= S1_W'(page) * S1_W'(tpp_sat);
    s2_r <= S2_W'(s1_r) * S2_W'(hc_sat);
    s3_r <= S3_W'(s2_r) * S3_W'(hw_sat);
  end

  // Track the stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign done   = v3_r;
  assign offset = s3_r[OFFSET_W-1:0];

endmodule

/* src/page_pool_allocator_unit.sv */
// Top level of the page pool allocator: sequencer, configuration and result register.
// The page pool allocator hands out page numbers from a last-in-first-out free
// stack held in a 1024-entry memory, next to a 1024-entry allocated bitmap.
// Requests are served one at a time: allocate, free and query are accepted with
// the memory read issued, then checked and written back in the next cycle;
// locate also passes through the registered multiplier chain that forms
// page * tokens_per_page * head_count * head_width. A pool reset rewrites
// both memories one entry per cycle. After rst_n the same clearing pass runs,
// during which in_stall stays high; configuration writes are taken at any
// time. Results sit in an output register, so the next request is accepted
// while a result waits on out_stall. pool_pages takes effect at the next
// pool reset.
module page_pool_allocator_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ppa_pkg::ppa_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ppa_pkg::ppa_out_t          out_data,
  input  logic                       cfg_we,
  input  logic [ppa_pkg::CFGI_W-1:0] cfg_index,
  input  logic [ppa_pkg::CFG_W-1:0]  cfg_data
);
  import ppa_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_LOOK  = 5'b00100,
    S_MUL   = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  ppa_in_t          req_r, req_nxt;
  ppa_out_t         res_r, res_nxt;
  ppa_out_t         out_data_r, out_data_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] free_count_r, free_count_nxt;
  logic [CNT_W-1:0] active_r, active_nxt;
  logic [IDX_W-1:0] clr_idx_r, clr_idx_nxt;
  logic             clr_reply_r, clr_reply_nxt;

  logic [POOL_W-1:0] pool_pages_r;
  logic [TPP_W-1:0]  tokens_per_page_r;
  logic [HC_W-1:0]   head_count_r;
  logic [HW_W-1:0]   head_width_r;

  ppa_mem_req_t     mem_req;
  logic [IDX_W-1:0] stk_rd;
  logic             map_rd;
  logic             off_start;
  logic             off_done;
  logic [OFFSET_W-1:0] off_result;

  // Store configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_pages_r      <= POOL_W'(1024);
      tokens_per_page_r <= TPP_W'(16);
      head_count_r      <= HC_W'(8);
      head_width_r      <= HW_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POOL_PAGES:      pool_pages_r      <= cfg_data[POOL_W-1:0];
        CFG_TOKENS_PER_PAGE: tokens_per_page_r <= cfg_data[TPP_W-1:0];
        CFG_HEAD_COUNT:      head_count_r      <= cfg_data[HC_W-1:0];
        CFG_HEAD_WIDTH:      head_width_r      <= cfg_data[HW_W-1:0];
        default: ;
      endcase
    end
  end

  ppa_store u_store (
    .clk    (clk),
    .req    (mem_req),
    .stk_rd (stk_rd),
    .map_rd (map_rd)
  );

  ppa_offset u_offset (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (off_start),
    .page            (req_r.page_id),
    .tokens_per_page (tokens_per_page_r),
    .head_count      (head_count_r),
    .head_width      (head_width_r),
    .done            (off_done),
    .offset          (off_result)
  );

  // Sequence one request: read, check, write back, respond
  always_comb begin
    logic     out_free;
    logic     page_ok;
    logic     go_mul;
    logic     go_clear;
    ppa_out_t res_look;
    ppa_out_t res_mul;
    logic [CNT_W-1:0] pool_sat;

    state_nxt      = state_r;
    req_nxt        = req_r;
    res_nxt        = res_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r & out_stall;
    free_count_nxt = free_count_r;
    active_nxt     = active_r;
    clr_idx_nxt    = clr_idx_r;
    clr_reply_nxt  = clr_reply_r;
    off_start      = 1'b0;
    go_mul         = 1'b0;
    go_clear       = 1'b0;

    out_free = !out_valid_r || !out_stall;
    page_ok  = 32'(req_r.page_id) < 32'(active_r);
    pool_sat = (32'(pool_pages_r) > 32'(MAX_PAGES)) ? CNT_W'(MAX_PAGES)
                                                    : CNT_W'(pool_pages_r);

    // Reads are issued every cycle; they matter at accept
    mem_req             = '0;
    mem_req.map_rd_addr = IDX_W'(in_data.page_id);
    mem_req.stk_rd_addr = free_count_r[IDX_W-1:0] - IDX_W'(1);

    res_look                = '0;
    res_look.status         = STATUS_OK;
    res_look.page_number    = req_r.page_id;
    res_mul                 = res_r;
    res_mul.element_offset  = off_result;

    unique case (state_r)
      S_CLEAR: begin
        mem_req.stk_we    = 1'b1;
        mem_req.stk_waddr = clr_idx_r;
        mem_req.stk_wdata = clr_idx_r;
        mem_req.map_we    = 1'b1;
        mem_req.map_waddr = clr_idx_r;
        mem_req.map_wdata = 1'b0;
        if (clr_idx_r == IDX_W'(MAX_PAGES - 1)) begin
          clr_idx_nxt   = '0;
          clr_reply_nxt = 1'b0;
          state_nxt     = clr_reply_r ? S_FIN : S_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + IDX_W'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        unique case (req_r.kind)
          KIND_ALLOC: begin
            res_look.page_number = '0;
            if (free_count_r == '0) begin
              res_look.status = STATUS_EXHAUSTED;
            end else begin
              res_look.page_number = PAGE_W'(stk_rd);
              mem_req.map_we       = 1'b1;
              mem_req.map_waddr    = stk_rd;
              mem_req.map_wdata    = 1'b1;
              free_count_nxt       = free_count_r - CNT_W'(1);
            end
          end
          KIND_FREE: begin
            if (!page_ok) begin
              res_look.status = STATUS_INVALID;
            end else if (!map_rd) begin
              res_look.status = STATUS_NOT_ALLOC;
            end else if (32'(free_count_r) < 32'(MAX_PAGES)) begin
              mem_req.map_we    = 1'b1;
              mem_req.map_waddr = IDX_W'(req_r.page_id);
              mem_req.map_wdata = 1'b0;
              mem_req.stk_we    = 1'b1;
              mem_req.stk_waddr = free_count_r[IDX_W-1:0];
              mem_req.stk_wdata = IDX_W'(req_r.page_id);
              free_count_nxt    = free_count_r + CNT_W'(1);
            end
          end
          KIND_LOCATE: begin
            if (!page_ok) begin
              res_look.status = STATUS_INVALID;
            end else if (!map_rd) begin
              res_look.status = STATUS_NOT_ALLOC;
            end else begin
              go_mul = 1'b1;
            end
          end
          KIND_QUERY: begin
            if (!page_ok) begin
              res_look.status = STATUS_INVALID;
            end else begin
              res_look.allocated_flag = map_rd;
            end
          end
          KIND_RESET: begin
            go_clear       = 1'b1;
            active_nxt     = pool_sat;
            free_count_nxt = pool_sat;
            clr_reply_nxt  = 1'b1;
          end
          default: ;
        endcase

        res_nxt = res_look;
        if (go_mul) begin
          off_start = 1'b1;
          state_nxt = S_MUL;
        end else if (go_clear) begin
          state_nxt = S_CLEAR;
        end else if (out_free) begin
          out_data_nxt  = res_look;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_MUL: begin
        if (off_done) begin
          res_nxt = res_mul;
          if (out_free) begin
            out_data_nxt  = res_mul;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      out_valid_r  <= 1'b0;
      free_count_r <= CNT_W'(MAX_PAGES);
      active_r     <= CNT_W'(MAX_PAGES);
      clr_idx_r    <= '0;
      clr_reply_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      free_count_r <= free_count_nxt;
      active_r     <= active_nxt;
      clr_idx_r    <= clr_idx_nxt;
      clr_reply_r  <= clr_reply_nxt;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* src/ppa_checker.sv */
// Port-level checker for the page pool allocator, bound to the top level.
`include "assert_macros.svh"

module ppa_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input ppa_pkg::ppa_in_t           in_data,
  input logic                       out_valid,
  input logic                       out_stall,
  input ppa_pkg::ppa_out_t          out_data,
  input logic                       cfg_we,
  input logic [ppa_pkg::CFGI_W-1:0] cfg_index,
  input logic [ppa_pkg::CFG_W-1:0]  cfg_data
);
  import ppa_pkg::*;

  logic unused_inputs;
  assign unused_inputs = in_valid ^ in_stall ^ (^in_data) ^ cfg_we ^ (^cfg_index) ^ (^cfg_data);

  // A stalled result stays offered
  `PPA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  // A stalled result keeps its payload
  `PPA_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data))

  // An exhausted pool hands out no page
  `PPA_ASSERT_NOW(a_exhaust_page, clk, rst_n, out_valid && out_data.status == STATUS_EXHAUSTED, out_data.page_number == '0)

  // A failed request carries neither flag nor offset
  `PPA_ASSERT_NOW(a_fail_clean, clk, rst_n, out_valid && out_data.status != STATUS_OK, !out_data.allocated_flag && out_data.element_offset == '0)

endmodule

bind page_pool_allocator_unit ppa_checker u_ppa_checker (.*);
